// File: src/rtt_est_pkg.sv
// Shared constants and types for the round-trip estimate cache.
package rtt_est_pkg;

   // Cache geometry and smoothing gains
   localparam int CACHE_ENTRIES  = 16;
   localparam int SRTT_GAIN_LOG2 = 3;
   localparam int MDEV_GAIN_LOG2 = 2;

   // Field widths
   localparam int ADDR_W = 32;
   localparam int TIME_W = 31;
   localparam int HASH_W = 16;
   localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   // Accumulator for the rounded averages: sample width plus gain plus carry
   localparam int GAIN_MAX = (SRTT_GAIN_LOG2 > MDEV_GAIN_LOG2) ? SRTT_GAIN_LOG2
                                                                : MDEV_GAIN_LOG2;
   localparam int ACC_W    = TIME_W + GAIN_MAX + 1;

   // Reciprocal for the index reduction: ceil(2^32 / CACHE_ENTRIES).
   // Exact quotient for any 16-bit hash and any entry count up to 2^16.
   localparam int RECIP_SH = 32;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam logic [RECIP_W-1:0] IDX_RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(CACHE_ENTRIES) - 64'd1) / 64'(CACHE_ENTRIES));
   localparam int PROD_W   = HASH_W + RECIP_W;

   // Action codes
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // Controller states
   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_INDEX = 6'b000100,
      ST_READ  = 6'b001000,
      ST_CALC  = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   // One cache entry
   typedef struct packed {
      logic [ADDR_W-1:0] tag;
      logic [TIME_W-1:0] srtt;
      logic [TIME_W-1:0] mdev;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load_item;
      logic load_quot;
      logic read_en;
      logic load_calc;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

// File: src/rtt_estimate_cache_top.sv
// Top level of the round-trip estimate cache.
// Direct-mapped cache of smoothed round-trip time and mean deviation per remote
// address, indexed by the low 16 address bits modulo the entry count. An add
// transaction replaces the entry on a tag miss or updates the rounded averages on
// a hit; a lookup transaction returns the hit flag and stored values, zero on a
// miss. Address zero never hits and changes nothing. After reset the block runs a
// clearing pass over the tag table, one entry per cycle, with req_stall high. Each
// transaction then passes from acceptance to the result register through the
// controller's index, table read, compare and write-back steps around the entry
// table; the next request is taken only once the controller is back in idle after
// write-back, so no request is accepted while another is in flight. A finished
// result waits in its output register while rsp_stall is high, and the next
// request is accepted meanwhile.
module rtt_estimate_cache_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [rtt_est_pkg::ADDR_W-1:0] req_remote_address,
   input  logic [rtt_est_pkg::TIME_W-1:0] req_rtt_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic [rtt_est_pkg::TIME_W-1:0] rsp_smoothed_rtt,
   output logic [rtt_est_pkg::TIME_W-1:0] rsp_mean_deviation
);

   rtt_est_pkg::cmd_type    cmd;
   rtt_est_pkg::status_type status;

   // Sequencer
   rtt_est_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Table and arithmetic
   rtt_est_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_remote_address (req_remote_address),
      .req_rtt_sample     (req_rtt_sample),
      .rsp_hit            (rsp_hit),
      .rsp_smoothed_rtt   (rsp_smoothed_rtt),
      .rsp_mean_deviation (rsp_mean_deviation)
   );

endmodule

// File: src/rtt_est_ctrl.sv
// Sequencing controller for the round-trip estimate cache.
module rtt_est_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rtt_est_pkg::cmd_type    cmd,
   input  rtt_est_pkg::status_type status
);

   rtt_est_pkg::state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         rtt_est_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = rtt_est_pkg::ST_IDLE;
            end
         end
         rtt_est_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = rtt_est_pkg::ST_INDEX;
            end
         end
         rtt_est_pkg::ST_INDEX: begin
            cmd.load_quot = 1'b1;
            state_in      = rtt_est_pkg::ST_READ;
         end
         rtt_est_pkg::ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = rtt_est_pkg::ST_CALC;
         end
         rtt_est_pkg::ST_CALC: begin
            cmd.load_calc = 1'b1;
            state_in      = rtt_est_pkg::ST_WRITE;
         end
         rtt_est_pkg::ST_WRITE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = rtt_est_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtt_est_pkg::ST_CLEAR;
         end
      endcase
   end

   // Output register occupancy
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtt_est_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != rtt_est_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/rtt_est_dp.sv
// Datapath for the round-trip estimate cache: entry table, index reduction, smoothing.
module rtt_est_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtt_est_pkg::cmd_type                  cmd,
   output rtt_est_pkg::status_type               status,
   input  logic                                 req_action,
   input  logic [rtt_est_pkg::ADDR_W-1:0]       req_remote_address,
   input  logic [rtt_est_pkg::TIME_W-1:0]       req_rtt_sample,
   output logic                                 rsp_hit,
   output logic [rtt_est_pkg::TIME_W-1:0]       rsp_smoothed_rtt,
   output logic [rtt_est_pkg::TIME_W-1:0]       rsp_mean_deviation
);

   // Rounded exponential average: ((2^lg - 1) * old + sample + 2^(lg-1)) >> lg
   function automatic logic [rtt_est_pkg::TIME_W-1:0] smooth(
      input logic [rtt_est_pkg::TIME_W-1:0] old,
      input logic [rtt_est_pkg::TIME_W-1:0] sample,
      input int                             lg
   );
      logic [rtt_est_pkg::ACC_W-1:0] acc;
      acc = (rtt_est_pkg::ACC_W'(old) << lg) - rtt_est_pkg::ACC_W'(old)
            + rtt_est_pkg::ACC_W'(sample)
            + ((rtt_est_pkg::ACC_W'(1) << lg) >> 1);
      smooth = rtt_est_pkg::TIME_W'(acc >> lg);
   endfunction

   rtt_est_pkg::entry_type mem [rtt_est_pkg::CACHE_ENTRIES];

   logic [rtt_est_pkg::IDX_W-1:0]   clr_ff;
   logic                            action_ff;
   logic [rtt_est_pkg::ADDR_W-1:0]  addr_ff;
   logic [rtt_est_pkg::TIME_W-1:0]  sample_ff;
   logic [rtt_est_pkg::HASH_W-1:0]  quot_ff, quot_in;
   logic [rtt_est_pkg::PROD_W-1:0]  prod;
   logic [rtt_est_pkg::HASH_W-1:0]  qn, rem;
   logic [rtt_est_pkg::IDX_W-1:0]   idx_ff, idx_in;
   rtt_est_pkg::entry_type          rd_ff;
   logic                            hit_ff, hit_in;
   logic [rtt_est_pkg::TIME_W-1:0]  err_ff, err_in;
   logic                            addr_nz;
   logic                            wr_en;
   rtt_est_pkg::entry_type          wr_entry;
   logic [rtt_est_pkg::TIME_W-1:0]  new_srtt, new_mdev;
   logic                            rsp_hit_ff;
   logic [rtt_est_pkg::TIME_W-1:0]  rsp_srtt_ff, rsp_mdev_ff;
   logic                            rsp_hit_in;
   logic [rtt_est_pkg::TIME_W-1:0]  rsp_srtt_in, rsp_mdev_in;

   // Clearing pass counter after reset
   assign status.clear_last = (clr_ff == rtt_est_pkg::IDX_W'(rtt_est_pkg::CACHE_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr && !status.clear_last) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_action;
         addr_ff   <= req_remote_address;
         sample_ff <= req_rtt_sample;
      end
   end

   // Index = hash mod entries: quotient by reciprocal, then remainder
   assign prod    = rtt_est_pkg::PROD_W'(addr_ff[rtt_est_pkg::HASH_W-1:0])
                    * rtt_est_pkg::PROD_W'(rtt_est_pkg::IDX_RECIP);
   assign quot_in = prod[rtt_est_pkg::RECIP_SH +: rtt_est_pkg::HASH_W];
   assign qn      = rtt_est_pkg::HASH_W'(32'(quot_ff) * 32'(rtt_est_pkg::CACHE_ENTRIES));
   assign rem     = addr_ff[rtt_est_pkg::HASH_W-1:0] - qn;
   assign idx_in  = rem[rtt_est_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_quot) begin
         quot_ff <= quot_in;
      end
      if (cmd.read_en) begin
         idx_ff <= idx_in;
      end
   end

   // Entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[idx_ff] <= wr_entry;
      end
      if (cmd.read_en) begin
         rd_ff <= mem[idx_in];
      end
   end

   // Tag compare and absolute error
   assign addr_nz = (addr_ff != '0);
   assign hit_in  = addr_nz && (rd_ff.tag == addr_ff);
   assign err_in  = (sample_ff > rd_ff.srtt) ? (sample_ff - rd_ff.srtt)
                                             : (rd_ff.srtt - sample_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_calc) begin
         hit_ff <= hit_in;
         err_ff <= err_in;
      end
   end

   // Update values
   assign new_srtt = smooth(rd_ff.srtt, sample_ff, rtt_est_pkg::SRTT_GAIN_LOG2);
   assign new_mdev = smooth(rd_ff.mdev, err_ff, rtt_est_pkg::MDEV_GAIN_LOG2);

   always_comb begin
      wr_entry.tag = addr_ff;
      if (hit_ff) begin
         wr_entry.srtt = new_srtt;
         wr_entry.mdev = new_mdev;
      end else begin
         wr_entry.srtt = sample_ff;
         wr_entry.mdev = '0;
      end
   end

   assign wr_en = cmd.commit && addr_nz && (action_ff == rtt_est_pkg::ACT_ADD);

   // Result selection
   always_comb begin
      rsp_hit_in  = hit_ff;
      rsp_srtt_in = '0;
      rsp_mdev_in = '0;
      if (addr_nz && (action_ff == rtt_est_pkg::ACT_ADD)) begin
         rsp_srtt_in = wr_entry.srtt;
         rsp_mdev_in = wr_entry.mdev;
      end else if (hit_ff) begin
         rsp_srtt_in = rd_ff.srtt;
         rsp_mdev_in = rd_ff.mdev;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_srtt_ff <= rsp_srtt_in;
         rsp_mdev_ff <= rsp_mdev_in;
      end
   end

   assign rsp_hit            = rsp_hit_ff;
   assign rsp_smoothed_rtt   = rsp_srtt_ff;
   assign rsp_mean_deviation = rsp_mdev_ff;

endmodule

// File: src/rtt_est_checker.sv
// Port-level checks for the round-trip estimate cache, bound to the top level.
module rtt_est_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_hit,
   input logic [rtt_est_pkg::TIME_W-1:0] rsp_smoothed_rtt,
   input logic [rtt_est_pkg::TIME_W-1:0] rsp_mean_deviation
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hit) && $stable(rsp_smoothed_rtt)
                                 && $stable(rsp_mean_deviation))
      else $error("result payload changed while stalled");

   // One transaction at a time: stall follows every acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   // Clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request port open during clearing pass");

   // Any miss carries a zero deviation
   a_miss_zero_mdev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_mean_deviation == '0)
      else $error("nonzero deviation on a miss");

endmodule

bind rtt_estimate_cache_top rtt_est_checker u_checker (.*);
